// ===== design/ism_pkg.sv =====
// shared types for the interval sort and merge block
package ism_pkg;

    // one range as it arrives
    typedef struct packed {
        logic [31:0] range_base;
        logic [31:0] range_size;
        logic        final_range;
    } ism_in_t;

    // one merged range as it leaves
    typedef struct packed {
        logic [31:0] merged_base;
        logic [32:0] merged_size;
        logic        final_merged;
        logic        overflowed;
    } ism_out_t;

    // contents of one chain cell
    typedef struct packed {
        logic        valid;
        logic [31:0] base;
        logic [32:0] end_addr;
    } ism_entry_t;

    // control broadcast to every cell
    typedef struct packed {
        logic        insert;
        logic        pop;
        logic [31:0] base;
        logic [32:0] end_addr;
    } ism_ctrl_t;

    // top level phases
    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } ism_state_t;

endpackage

// ===== design/ism_cell.sv =====
// one cell of the sorted insertion chain
module ism_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ism_pkg::ism_ctrl_t  ctrl,
    input  ism_pkg::ism_entry_t left_entry,
    input  logic                left_place,
    input  ism_pkg::ism_entry_t right_entry,
    output ism_pkg::ism_entry_t entry,
    output logic                place
);
    import ism_pkg::*;

    logic        valid_reg;
    logic [31:0] base_reg;
    logic [32:0] end_reg;

    assign entry = '{valid: valid_reg, base: base_reg, end_addr: end_reg};

    // new range lands here or before: empty cell or larger stored base
    assign place = !valid_reg || (base_reg > ctrl.base);

    // valid bit: shift right on insert, shift left on pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.insert && place)
        begin
            valid_reg <= left_place ? left_entry.valid : 1'b1;
        end
        else if (ctrl.pop)
        begin
            valid_reg <= right_entry.valid;
        end
    end

    // payload follows the same moves
    always_ff @(posedge clk)
    begin
        if (ctrl.insert && place)
        begin
            if (left_place)
            begin
                base_reg <= left_entry.base;
                end_reg  <= left_entry.end_addr;
            end
            else
            begin
                base_reg <= ctrl.base;
                end_reg  <= ctrl.end_addr;
            end
        end
        else if (ctrl.pop)
        begin
            base_reg <= right_entry.base;
            end_reg  <= right_entry.end_addr;
        end
    end

endmodule

// ===== design/ism_merge.sv =====
// merge unit: walks the chain head and emits merged ranges
module ism_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                active,
    input  logic                overflow,
    input  ism_pkg::ism_entry_t head,
    output logic                pop,
    output logic                done,
    input  logic                merged_stall,
    output logic                merged_valid,
    output ism_pkg::ism_out_t   merged_item
);
    import ism_pkg::*;

    logic        cur_valid_reg;
    logic [31:0] cur_base_reg;
    logic [32:0] cur_end_reg;
    logic        out_valid_reg;
    ism_out_t    out_item_reg;

    logic        out_free;
    logic        joins;
    logic        take_head;
    logic        emit;
    logic [32:0] cur_size;

    assign out_free = !out_valid_reg || !merged_stall;
    assign joins    = {1'b0, head.base} <= cur_end_reg;
    assign cur_size = cur_end_reg - {1'b0, cur_base_reg};

    // step decisions
    always_comb
    begin
        pop       = 1'b0;
        take_head = 1'b0;
        emit      = 1'b0;
        done      = 1'b0;
        if (active)
        begin
            if (head.valid)
            begin
                if (!cur_valid_reg)
                begin
                    pop       = 1'b1;
                    take_head = 1'b1;
                end
                else if (joins)
                begin
                    pop = 1'b1;
                end
                else if (out_free)
                begin
                    pop       = 1'b1;
                    take_head = 1'b1;
                    emit      = 1'b1;
                end
            end
            else if (cur_valid_reg && out_free)
            begin
                emit = 1'b1;
                done = 1'b1;
            end
        end
    end

    // running merged range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (take_head)
        begin
            cur_valid_reg <= 1'b1;
        end
        else if (done)
        begin
            cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_head)
        begin
            cur_base_reg <= head.base;
            cur_end_reg  <= head.end_addr;
        end
        else if (pop && (head.end_addr > cur_end_reg))
        begin
            cur_end_reg <= head.end_addr;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!merged_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg <= '{merged_base: cur_base_reg, merged_size: cur_size,
                              final_merged: done, overflowed: overflow};
        end
    end

    assign merged_valid = out_valid_reg;
    assign merged_item  = out_item_reg;

endmodule

// ===== design/interval_sort_merge_core.sv =====
// top level of the interval sort and merge block
//
// Ranges come in on the range channel (range_valid, range_stall, range_item),
// one base and size per item, the last item of a set marked by final_range.
// While loading, one item is taken every cycle and dropped into a chain of
// MAX_RANGES cells that keeps the ranges ordered by base; the compare in each
// cell and the one-step shift set that rate. Items beyond MAX_RANGES are
// dropped and every result of that set carries overflowed.
// After the final item the chain drains one cell per cycle into the merge
// unit, unless a finished range waits on a stalled output register; merged
// ranges leave on the merged channel (merged_valid, merged_stall, merged_item),
// ascending, the last marked by final_merged.
// range_stall is high during the drain; loading of the next set starts as
// soon as the last result sits in the output register.
// Reset empties the chain and the counters at once; no clearing pass.
module interval_sort_merge_core #(
    parameter int MAX_RANGES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              range_valid,
    output logic              range_stall,
    input  ism_pkg::ism_in_t  range_item,
    output logic              merged_valid,
    input  logic              merged_stall,
    output ism_pkg::ism_out_t merged_item
);
    import ism_pkg::*;

    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    ism_state_t       state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             overflow_reg;

    logic             accept;
    logic             full;
    logic             pop;
    logic             done;
    ism_ctrl_t        ctrl;
    ism_entry_t       entries [MAX_RANGES];
    logic             places  [MAX_RANGES];

    assign range_stall = (state_reg != ST_LOAD);
    assign accept      = range_valid && !range_stall;
    assign full        = (count_reg == CNT_W'(MAX_RANGES));

    // broadcast to the chain
    assign ctrl.insert   = accept && !full;
    assign ctrl.pop      = pop;
    assign ctrl.base     = range_item.range_base;
    assign ctrl.end_addr = {1'b0, range_item.range_base} + {1'b0, range_item.range_size};

    // phase, fill count and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (full)
                        begin
                            overflow_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (range_item.final_range)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (done)
                    begin
                        state_reg    <= ST_LOAD;
                        count_reg    <= '0;
                        overflow_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // sorted insertion chain
    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        ism_entry_t left_entry;
        logic       left_place;
        ism_entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_place = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = entries[i-1];
            assign left_place = places[i-1];
        end

        if (i == MAX_RANGES - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_mid
            assign right_entry = entries[i+1];
        end

        ism_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_entry  (left_entry),
            .left_place  (left_place),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .place       (places[i])
        );
    end

    // merge unit on the chain head
    ism_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .active       (state_reg == ST_DRAIN),
        .overflow     (overflow_reg),
        .head         (entries[0]),
        .pop          (pop),
        .done         (done),
        .merged_stall (merged_stall),
        .merged_valid (merged_valid),
        .merged_item  (merged_item)
    );

`ifndef SYNTHESIS
    // chain only drains in the drain phase
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_DRAIN))
        else $error("chain popped outside drain");

    // fill count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RANGES))
        else $error("fill count beyond capacity");

    // while loading, the head cell is filled exactly when the count is nonzero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (entries[0].valid == (count_reg != '0)))
        else $error("chain head and fill count disagree");

    // the last result of a set sends the block back to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == ST_LOAD) && (count_reg == '0))
        else $error("set not closed after last result");
`endif

endmodule

// ===== tb/sv/tb_interval_sort_merge_core.sv =====
// testbench for interval_sort_merge_core: directed plan, random range sets, merge predictor
module tb_interval_sort_merge_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ism_pkg::*;

    localparam int MAX_RANGES     = 64;
    localparam int DIRECTED_ROWS  = 21;
    localparam int TOTAL_ITEMS    = 480;
    localparam int PHASE_ITEMS    = 160;
    localparam int WATCHDOG_LIMIT = 2000;

    // one row of the directed plan, with an optional hand-written result
    typedef struct packed {
        ism_in_t  item;
        logic     typed;
        ism_out_t result;
    } plan_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     range_valid = 1'b0;
    logic     range_stall;
    ism_in_t  range_item = '0;
    logic     merged_valid;
    logic     merged_stall = 1'b0;
    ism_out_t merged_item;

    // handshake pressure, changed as the run moves through its phases
    int send_idle_pct = 25;
    int recv_stall_pct = 83;
    int items_sent = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // predictor state: ranges held in base order, plus the dropped flag
    logic [31:0] held_base [MAX_RANGES];
    logic [32:0] held_end [MAX_RANGES];
    int          held_count = 0;
    logic        ranges_dropped = 1'b0;
    ism_out_t    merged_expect [$];

    plan_row_t directed_plan [DIRECTED_ROWS] = '{
        // lone ranges at the field extremes
        '{'{32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1,
          '{32'h0000_0000, 33'h0_0000_0000, 1'b1, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
          '{32'hFFFF_FFFF, 33'h0_FFFF_FFFF, 1'b1, 1'b0}},
        '{'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1}, 1'b1,
          '{32'h0000_0000, 33'h0_FFFF_FFFF, 1'b1, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'h0000_0000, 1'b1}, 1'b1,
          '{32'hFFFF_FFFF, 33'h0_0000_0000, 1'b1, 1'b0}},
        // touching ranges join
        '{'{32'h0000_0100, 32'h0000_0010, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0110, 32'h0000_0005, 1'b1}, 1'b0, '0},
        // disjoint ranges arriving out of order
        '{'{32'h0000_0300, 32'h0000_0010, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0100, 32'h0000_0010, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0200, 32'h0000_0001, 1'b1}, 1'b0, '0},
        // equal bases
        '{'{32'h0000_0500, 32'h0000_0020, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0500, 32'h0000_0005, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0500, 32'h0000_0040, 1'b1}, 1'b0, '0},
        // zero sizes inside, at the end and past the end
        '{'{32'h0000_0600, 32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0600, 32'h0000_0010, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0610, 32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0611, 32'h0000_0000, 1'b1}, 1'b0, '0},
        // contained range, and an end above 32 bits
        '{'{32'h0000_1000, 32'h0000_0100, 1'b0}, 1'b0, '0},
        '{'{32'h0000_1010, 32'h0000_0005, 1'b0}, 1'b0, '0},
        '{'{32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
        // alternating bit patterns
        '{'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0}, 1'b0, '0},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 1'b1}, 1'b0, '0}
    };

    interval_sort_merge_core #(
        .MAX_RANGES(MAX_RANGES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .range_valid(range_valid),
        .range_stall(range_stall),
        .range_item(range_item),
        .merged_valid(merged_valid),
        .merged_stall(merged_stall),
        .merged_item(merged_item)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hold one range in base order; on the last range walk the set and merge
    function automatic void fold_range(input ism_in_t it, output ism_out_t due [$]);
        int          pos;
        logic [31:0] cur_base;
        logic [32:0] cur_end;
        ism_out_t    r;
        due = {};
        if (held_count < MAX_RANGES)
        begin
            pos = held_count;
            while (pos > 0 && held_base[pos - 1] > it.range_base)
            begin
                held_base[pos] = held_base[pos - 1];
                held_end[pos] = held_end[pos - 1];
                pos--;
            end
            held_base[pos] = it.range_base;
            held_end[pos] = {1'b0, it.range_base} + {1'b0, it.range_size};
            held_count++;
        end
        else
        begin
            ranges_dropped = 1'b1;
        end
        if (!it.final_range)
            return;
        cur_base = held_base[0];
        cur_end = held_end[0];
        for (int i = 1; i < held_count; i++)
        begin
            if ({1'b0, held_base[i]} <= cur_end)
            begin
                if (held_end[i] > cur_end)
                    cur_end = held_end[i];
            end
            else
            begin
                r.merged_base = cur_base;
                r.merged_size = cur_end - {1'b0, cur_base};
                r.final_merged = 1'b0;
                r.overflowed = ranges_dropped;
                due.push_back(r);
                cur_base = held_base[i];
                cur_end = held_end[i];
            end
        end
        r.merged_base = cur_base;
        r.merged_size = cur_end - {1'b0, cur_base};
        r.final_merged = 1'b1;
        r.overflowed = ranges_dropped;
        due.push_back(r);
        held_count = 0;
        ranges_dropped = 1'b0;
    endfunction

    // offer one range after a random gap, then record what it should produce
    task automatic send_range(input ism_in_t it, input logic typed, input ism_out_t typed_res);
        ism_out_t due [$];
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            range_valid <= 1'b0;
            @(posedge clk);
        end
        range_valid <= 1'b1;
        range_item <= it;
        @(posedge clk);
        while (range_stall)
            @(posedge clk);
        fold_range(it, due);
        if (typed)
            merged_expect.push_back(typed_res);
        else
            foreach (due[j])
                merged_expect.push_back(due[j]);
        items_sent++;
        // idling phases: sender light then heavy, then none
        if (items_sent == PHASE_ITEMS)
        begin
            send_idle_pct = 83;
            recv_stall_pct = 25;
        end
        else if (items_sent == 2 * PHASE_ITEMS)
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end
    endtask

    // one random set: clustered overlaps, full disjoint sets, overflow, wide and top-end ranges
    task automatic send_random_set();
        int          kind;
        int          n;
        logic [31:0] win;
        ism_in_t     it;
        kind = $urandom_range(0, 99);
        win = $urandom;
        if (kind < 6)
            n = MAX_RANGES;
        else if (kind < 12)
            n = $urandom_range(MAX_RANGES + 1, MAX_RANGES + 8);
        else
            n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
        begin
            if (kind < 6)
            begin
                // every range its own result, shuffled order
                it.range_base = win + 32'((k * 37) % MAX_RANGES) * 8;
                it.range_size = $urandom_range(0, 6);
            end
            else if (kind < 70)
            begin
                it.range_base = win + $urandom_range(0, 511);
                it.range_size = $urandom_range(0, 64);
            end
            else if (kind < 85)
            begin
                it.range_base = $urandom;
                it.range_size = $urandom;
            end
            else
            begin
                it.range_base = 32'hFFFF_FF00 | $urandom_range(0, 255);
                it.range_size = (k % 2 == 1) ? $urandom : $urandom_range(0, 300);
            end
            it.final_range = (k == n - 1);
            send_range(it, 1'b0, '0);
        end
    endtask

    // receiver stall
    always @(posedge clk)
    begin
        merged_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // compare each merged item with the oldest expectation
    always @(posedge clk)
    begin : check_merged
        ism_out_t want;
        logic     bad;
        if (rst_n && merged_valid && !merged_stall)
        begin
            if (merged_expect.size() == 0)
            begin
                $display("%0t unexpected merged item: expected none got %h", $time, merged_item);
                mismatches++;
            end
            else
            begin
                want = merged_expect.pop_front();
                bad = 1'b0;
                if (merged_item.merged_base !== want.merged_base)
                begin
                    $display("%0t merged_base: expected %h got %h",
                             $time, want.merged_base, merged_item.merged_base);
                    bad = 1'b1;
                end
                if (merged_item.merged_size !== want.merged_size)
                begin
                    $display("%0t merged_size: expected %h got %h",
                             $time, want.merged_size, merged_item.merged_size);
                    bad = 1'b1;
                end
                if (merged_item.final_merged !== want.final_merged)
                begin
                    $display("%0t final_merged: expected %b got %b",
                             $time, want.final_merged, merged_item.final_merged);
                    bad = 1'b1;
                end
                if (merged_item.overflowed !== want.overflowed)
                begin
                    $display("%0t overflowed: expected %b got %b",
                             $time, want.overflowed, merged_item.overflowed);
                    bad = 1'b1;
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (range_valid && !range_stall) || (merged_valid && !merged_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[interval_sort_merge_core] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, directed plan, random sets, drain
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_plan[r])
            send_range(directed_plan[r].item, directed_plan[r].typed, directed_plan[r].result);
        while (items_sent < TOTAL_ITEMS)
            send_random_set();
        range_valid <= 1'b0;
        while (merged_expect.size() != 0)
            @(posedge clk);
        repeat (MAX_RANGES + 8) @(posedge clk);
        if (mismatches == 0)
            $display("[interval_sort_merge_core] OK");
        else
            $display("[interval_sort_merge_core] ERROR");
        $finish;
    end

endmodule
